@@ sv/fpdtf_pkg.sv @@
`timescale 1ns / 1ps
// Package for the fixed-point decimal text formatter.
// Holds widths, ASCII codes, state types and the descriptor passed from front to back.
// Depends on nothing.
package fpdtf_pkg;

  localparam int MAX_WIDTH  = 10;
  localparam int VALUE_W    = 32;
  localparam int POINT_W    = 4;
  localparam int FIELD_W    = 4;
  localparam int CHAR_W     = 7;

  // A 32-bit magnitude has at most ten decimal digits.
  localparam int NUM_DIGITS = 10;
  localparam int DIG_IDX_W  = $clog2(NUM_DIGITS);
  localparam int NDIG_W     = $clog2(NUM_DIGITS + 1);
  localparam int WIDTH_W    = $clog2(MAX_WIDTH + 1);
  localparam int POS_W      = $clog2(MAX_WIDTH);
  // Point position plus two, or a position index, whichever is larger.
  localparam int TOTAL_W    = 5;

  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int QCNT_W     = $clog2(QDEPTH + 1);

  // Reciprocal of ten: q = (m * RECIP10) >> RECIP_SHIFT is exact for 32-bit m.
  localparam logic [31:0] RECIP10     = 32'hCCCC_CCCD;
  localparam int          RECIP_SHIFT = 35;

  localparam logic [CHAR_W-1:0] CH_SPACE   = 7'h20;
  localparam logic [CHAR_W-1:0] CH_ZERO    = 7'h30;
  localparam logic [CHAR_W-1:0] CH_NINE    = 7'h39;
  localparam logic [CHAR_W-1:0] CH_POINT   = 7'h2E;
  localparam logic [CHAR_W-1:0] CH_MINUS   = 7'h2D;
  localparam logic [CHAR_W-1:0] CH_NEWLINE = 7'h0A;

  typedef enum logic [1:0] {
    FR_IDLE,
    FR_CONV,
    FR_PUSH
  } front_state_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_CHAR,
    BK_NL
  } back_state_t;

  // One converted item: its digits (least significant first) and layout.
  typedef struct packed {
    logic [NUM_DIGITS-1:0][3:0] digits;
    logic                       neg;
    logic [POINT_W-1:0]         point;
    logic [WIDTH_W-1:0]         width;
    logic [TOTAL_W-1:0]         total;
  } fmt_desc_t;

endpackage

@@ sv/fpdtf_if.sv @@
`timescale 1ns / 1ps
// Channel interfaces for the formatter: input items and output characters.
// Depends on fpdtf_pkg.
interface fpdtf_item_if
  import fpdtf_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value;
  logic [POINT_W-1:0] point_position;
  logic [FIELD_W-1:0] field_width;

  modport source (output valid, output value, output point_position, output field_width,
                  input ready);
  modport sink   (input valid, input value, input point_position, input field_width,
                  output ready);
endinterface

interface fpdtf_result_if
  import fpdtf_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] character;
  logic              is_last;

  modport source (output valid, output character, output is_last, input ready);
  modport sink   (input valid, input character, input is_last, output ready);
endinterface

@@ sv/fpdtf_front.sv @@
`timescale 1ns / 1ps
// Front part: accepts an item and extracts its decimal digits, one per cycle.
// Depends on fpdtf_pkg and fpdtf_if.
module fpdtf_front
  import fpdtf_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  fpdtf_item_if.sink       item,
  output logic             push,
  output fmt_desc_t        push_desc,
  input  logic             q_full
);

  front_state_t               state, state_next;
  logic [VALUE_W-1:0]         mag;
  logic                       neg;
  logic [POINT_W-1:0]         point;
  logic [WIDTH_W-1:0]         width;
  logic [NUM_DIGITS-1:0][3:0] digits;
  logic [NDIG_W-1:0]          ndig;
  logic [DIG_IDX_W-1:0]       step;

  logic [2*VALUE_W-1:0]       prod;
  logic [VALUE_W-1:0]         quo;
  logic [VALUE_W-1:0]         quo10;
  logic [3:0]                 rem;
  logic [WIDTH_W-1:0]         width_in;
  logic [TOTAL_W-1:0]         total;

  // Divide by ten through the reciprocal; times ten is two shifts and an add.
  always_comb begin
    prod  = (2*VALUE_W)'(mag) * (2*VALUE_W)'(RECIP10);
    quo   = VALUE_W'(prod >> RECIP_SHIFT);
    quo10 = (quo << 3) + (quo << 1);
    rem   = 4'(mag - quo10);
  end

  always_comb begin
    if (int'(item.field_width) > MAX_WIDTH) begin
      width_in = WIDTH_W'(MAX_WIDTH);
    end else begin
      width_in = WIDTH_W'(item.field_width);
    end
  end

  // Characters taken by the number itself, point included.
  always_comb begin
    if (point == '0) begin
      total = TOTAL_W'(ndig);
    end else if (TOTAL_W'(ndig) > TOTAL_W'(point)) begin
      total = TOTAL_W'(ndig) + TOTAL_W'(1);
    end else begin
      total = TOTAL_W'(point) + TOTAL_W'(2);
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      FR_IDLE: begin
        if (item.valid) state_next = FR_CONV;
      end
      FR_CONV: begin
        if (step == DIG_IDX_W'(NUM_DIGITS - 1)) state_next = FR_PUSH;
      end
      FR_PUSH: begin
        if (!q_full) state_next = FR_IDLE;
      end
      default: state_next = FR_IDLE;
    endcase
  end

  always_comb begin
    item.ready       = (state == FR_IDLE);
    push             = (state == FR_PUSH) && !q_full;
    push_desc.digits = digits;
    push_desc.neg    = neg;
    push_desc.point  = point;
    push_desc.width  = width;
    push_desc.total  = total;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FR_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      FR_IDLE: begin
        if (item.valid) begin
          neg   <= item.value[VALUE_W-1];
          mag   <= item.value[VALUE_W-1] ? (VALUE_W'(0) - item.value) : item.value;
          point <= item.point_position;
          width <= width_in;
          step  <= '0;
          ndig  <= NDIG_W'(1);
        end
      end
      FR_CONV: begin
        digits[step] <= rem;
        mag          <= quo;
        step         <= step + DIG_IDX_W'(1);
        if (rem != 4'd0) ndig <= NDIG_W'(step) + NDIG_W'(1);
      end
      default: begin
      end
    endcase
  end

endmodule

@@ sv/fpdtf_queue.sv @@
`timescale 1ns / 1ps
// Short descriptor queue between the converting front and the emitting back.
// Depends on fpdtf_pkg.
module fpdtf_queue
  import fpdtf_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  fmt_desc_t push_desc,
  output logic      full,
  input  logic      pop,
  output fmt_desc_t pop_desc,
  output logic      empty
);

  fmt_desc_t          mem [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;
  logic               do_push;
  logic               do_pop;

  always_comb begin
    full     = (count == QCNT_W'(QDEPTH));
    empty    = (count == '0);
    do_push  = push && !full;
    do_pop   = pop && !empty;
    pop_desc = mem[rd_ptr];
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_desc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

@@ sv/fpdtf_back.sv @@
`timescale 1ns / 1ps
// Back part: walks the field left to right and emits one character per transfer.
// Depends on fpdtf_pkg and fpdtf_if.
module fpdtf_back
  import fpdtf_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  fmt_desc_t     q_desc,
  input  logic          q_empty,
  output logic          q_pop,
  fpdtf_result_if.source result
);

  back_state_t        state, state_next;
  fmt_desc_t          desc;
  logic [POS_W-1:0]   k;         // position counted from the right edge
  logic               out_valid;
  logic [CHAR_W-1:0]  char_q;
  logic               last_q;

  logic               can_load;
  logic [TOTAL_W-1:0] kk;
  logic [TOTAL_W-1:0] dig_idx;
  logic [3:0]         dig;
  logic [CHAR_W-1:0]  char_now;

  // Character at position k from the right.
  always_comb begin
    kk = TOTAL_W'(k);
    if ((desc.point != '0) && (kk > TOTAL_W'(desc.point))) begin
      dig_idx = kk - TOTAL_W'(1);
    end else begin
      dig_idx = kk;
    end
    if (dig_idx < TOTAL_W'(NUM_DIGITS)) begin
      dig = desc.digits[dig_idx[DIG_IDX_W-1:0]];
    end else begin
      dig = 4'd0;
    end
    priority if (kk < desc.total) begin
      if ((desc.point != '0) && (kk == TOTAL_W'(desc.point))) begin
        char_now = CH_POINT;
      end else begin
        char_now = CH_ZERO | CHAR_W'(dig);
      end
    end else if ((kk == desc.total) && desc.neg) begin
      char_now = CH_MINUS;
    end else begin
      char_now = CH_SPACE;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (!q_empty) state_next = (q_desc.width == '0) ? BK_NL : BK_CHAR;
      end
      BK_CHAR: begin
        if (can_load && (k == '0)) state_next = BK_NL;
      end
      BK_NL: begin
        if (can_load) state_next = BK_IDLE;
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    can_load         = !out_valid || result.ready;
    q_pop            = (state == BK_IDLE) && !q_empty;
    result.valid     = out_valid;
    result.character = char_q;
    result.is_last   = last_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (can_load) out_valid <= (state == BK_CHAR) || (state == BK_NL);
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      desc <= q_desc;
      k    <= POS_W'(q_desc.width - WIDTH_W'(1));
    end
    if (can_load) begin
      if (state == BK_CHAR) begin
        char_q <= char_now;
        last_q <= 1'b0;
        k      <= k - POS_W'(1);
      end else if (state == BK_NL) begin
        char_q <= CH_NEWLINE;
        last_q <= 1'b1;
      end
    end
  end

endmodule

@@ sv/fixed_point_decimal_text_formatter_core.sv @@
`timescale 1ns / 1ps
// Top level of the fixed-point decimal text formatter.
// Depends on fpdtf_pkg, fpdtf_if, fpdtf_front, fpdtf_queue and fpdtf_back.
//
//  Channel  Role    Payload                               Transfers per item
//  -------  ------  ------------------------------------  ------------------------
//  item     sink    value, point_position, field_width    one
//  result   source  character, is_last                    width, max 10, plus one
//
// The front accepts an item, extracts its ten digits (one divide by ten per
// cycle through a 32 by 32 reciprocal multiply) and hands the descriptor to the
// two-entry queue. The back pops a descriptor and emits the field, then the
// newline. With both running at once the front's digit loop sets the sustained
// rate. Reset is synchronous and empties the queue and the output register.
// Either side may stall without stopping the other until the queue fills.
module fixed_point_decimal_text_formatter_core
  import fpdtf_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  fpdtf_item_if.sink      item,
  fpdtf_result_if.source  result
);

  // Descriptors from the front wait here until the back is free.
  logic      push;
  fmt_desc_t push_desc;
  logic      q_full;
  logic      q_pop;
  fmt_desc_t q_desc;
  logic      q_empty;

  // Front: accepts items, takes the magnitude apart into decimal digits and works
  // out how many characters the number occupies.
  fpdtf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .push      (push),
    .push_desc (push_desc),
    .q_full    (q_full)
  );

  fpdtf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_desc (push_desc),
    .full      (q_full),
    .pop       (q_pop),
    .pop_desc  (q_desc),
    .empty     (q_empty)
  );

  // Back: builds each character from its distance to the right edge, so digits,
  // point, sign and spaces come out left to right, then the newline marked last.
  // Anything that would lie left of the field is simply never reached.
  fpdtf_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_desc  (q_desc),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .result  (result)
  );

endmodule

@@ sv/fpdtf_checker.sv @@
`timescale 1ns / 1ps
// Port-level checks on the formatter's result channel, bound to the top level.
// Depends on fpdtf_pkg and fixed_point_decimal_text_formatter_core.
module fpdtf_checker
  import fpdtf_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              res_valid,
  input logic              res_ready,
  input logic [CHAR_W-1:0] character,
  input logic              is_last
);

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(character) && $stable(is_last))
    else $error("result changed while stalled");

  a_last_newline: assert property (@(posedge clk) disable iff (rst)
    res_valid && is_last |-> character == CH_NEWLINE)
    else $error("terminator is not a newline");

  a_field_chars: assert property (@(posedge clk) disable iff (rst)
    res_valid && !is_last |-> (character == CH_SPACE) || (character == CH_POINT) ||
      (character == CH_MINUS) || ((character >= CH_ZERO) && (character <= CH_NINE)))
    else $error("field character outside the expected set");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid right after reset");

endmodule

bind fixed_point_decimal_text_formatter_core fpdtf_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .res_valid (result.valid),
  .res_ready (result.ready),
  .character (result.character),
  .is_last   (result.is_last)
);

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench for the fixed-point decimal text formatter core.
// Depends on fpdtf_pkg, the fpdtf_if channel interfaces and the core itself.
module tb;
  import fpdtf_pkg::*;

  logic clk;
  logic rst;

  fpdtf_item_if   item_ch ();
  fpdtf_result_if result_ch ();

  fixed_point_decimal_text_formatter_core u_dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch)
  );

  typedef struct {
    logic [CHAR_W-1:0] character;
    logic              is_last;
  } text_char_t;

  // One directed row. Where typed is set, text holds the field contents
  // without the terminating newline; otherwise the formatter model decides.
  typedef struct {
    logic [VALUE_W-1:0] value;
    logic [POINT_W-1:0] point;
    logic [FIELD_W-1:0] width;
    bit                 typed;
    string              text;
  } directed_row_t;

  text_char_t        expected_chars[$];
  logic [CHAR_W-1:0] field_text[MAX_WIDTH];
  directed_row_t     directed_rows[$];

  int send_idle_pct;
  int recv_idle_pct;
  int failures;
  int items_sent;
  int chars_checked;
  int fields_checked;
  int directed_count;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Fires at two milliseconds of simulated time, well past the slowest
  // legal run with the heaviest stalls.
  initial begin
    #2ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Characters that would fall outside the field are simply dropped.
  function automatic void place_char(input int pos, input int w, input logic [CHAR_W-1:0] ch);
    if (pos >= 0 && pos < w) begin
      field_text[pos] = ch;
    end
  endfunction

  // Lays out one value as a right-aligned field and queues the characters
  // the core should emit for it, newline last.
  function automatic void format_field(input logic [VALUE_W-1:0] value,
                                       input logic [POINT_W-1:0] point,
                                       input logic [FIELD_W-1:0] fw);
    logic [VALUE_W-1:0] mag;
    logic [VALUE_W-1:0] t;
    logic               neg;
    int                 w;
    int                 pt;
    int                 ndig;
    int                 total;
    text_char_t         tc;
    neg = value[VALUE_W-1];
    // Two's complement wrap turns the most negative value into 2147483648.
    mag = neg ? -value : value;
    pt  = point;
    w   = (fw > MAX_WIDTH) ? MAX_WIDTH : fw;
    for (int i = 0; i < MAX_WIDTH; i++) begin
      field_text[i] = CH_SPACE;
    end
    ndig = 0;
    t    = mag;
    while (t != 0) begin
      ndig++;
      t = t / 10;
    end
    if (ndig == 0) begin
      ndig = 1;
    end
    total = ndig;
    t     = mag;
    if (pt > 0) begin
      place_char(w - 1 - pt, w, CH_POINT);
      // Short values gain fraction zeros and a single zero before the point.
      total = (total > pt) ? total + 1 : pt + 2;
      for (int i = 0; i < total - 1; i++) begin
        place_char((i < pt) ? w - 1 - i : w - 2 - i, w, CH_ZERO | CHAR_W'(t % 10));
        t = t / 10;
      end
    end else begin
      for (int i = 0; i < total; i++) begin
        place_char(w - 1 - i, w, CH_ZERO | CHAR_W'(t % 10));
        t = t / 10;
      end
    end
    if (neg && w > total) begin
      place_char(w - total - 1, w, CH_MINUS);
    end
    for (int i = 0; i < w; i++) begin
      tc.character = field_text[i];
      tc.is_last   = 1'b0;
      expected_chars.push_back(tc);
    end
    tc.character = CH_NEWLINE;
    tc.is_last   = 1'b1;
    expected_chars.push_back(tc);
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic drive_item(input logic [VALUE_W-1:0] value, input logic [POINT_W-1:0] point,
                            input logic [FIELD_W-1:0] width, input bit typed,
                            input string text);
    text_char_t tc;
    while ($urandom_range(99) < send_idle_pct) begin
      item_ch.valid <= 1'b0;
      @(negedge clk);
    end
    item_ch.valid          <= 1'b1;
    item_ch.value          <= value;
    item_ch.point_position <= point;
    item_ch.field_width    <= width;
    do @(posedge clk); while (!item_ch.ready);
    if (typed) begin
      for (int i = 0; i < text.len(); i++) begin
        tc.character = CHAR_W'(text[i]);
        tc.is_last   = 1'b0;
        expected_chars.push_back(tc);
      end
      tc.character = CH_NEWLINE;
      tc.is_last   = 1'b1;
      expected_chars.push_back(tc);
    end else begin
      format_field(value, point, width);
    end
    items_sent++;
    @(negedge clk);
  endtask

  // Receiver: stalls at random, decided at each falling edge.
  initial begin
    result_ch.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    text_char_t exp_char;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (expected_chars.size() == 0) begin
        $error("unexpected character transfer: character %h, is_last %b",
               result_ch.character, result_ch.is_last);
        failures++;
      end else begin
        exp_char = expected_chars.pop_front();
        chars_checked++;
        if (result_ch.character !== exp_char.character) begin
          $error("character: expected %h, actual %h", exp_char.character,
                 result_ch.character);
          failures++;
        end
        if (result_ch.is_last !== exp_char.is_last) begin
          $error("is_last: expected %b, actual %b", exp_char.is_last, result_ch.is_last);
          failures++;
        end
        if (exp_char.is_last) begin
          fields_checked++;
        end
      end
    end
  end

  initial begin
    logic [VALUE_W-1:0] value;
    logic [POINT_W-1:0] point;
    logic [FIELD_W-1:0] width;
    int                 tail;
    int                 phase;

    failures               = 0;
    items_sent             = 0;
    chars_checked          = 0;
    fields_checked         = 0;
    send_idle_pct          = 38;
    recv_idle_pct          = 66;
    rst                    = 1'b1;
    item_ch.valid          = 1'b0;
    item_ch.value          = '0;
    item_ch.point_position = '0;
    item_ch.field_width    = '0;

    // Zero, width zero, both extremes, sign handling, saturation of the
    // width, the point at and beyond the field edge, and cut-off on the left.
    directed_rows.push_back('{32'd0,          4'd0,  4'd1,  1'b1, "0"});
    directed_rows.push_back('{32'd0,          4'd0,  4'd0,  1'b1, ""});
    directed_rows.push_back('{32'h8000_0000,  4'd0,  4'd10, 1'b1, "2147483648"});
    directed_rows.push_back('{32'h7FFF_FFFF,  4'd0,  4'd10, 1'b1, "2147483647"});
    directed_rows.push_back('{32'hFFFF_FFFF,  4'd0,  4'd3,  1'b1, " -1"});
    directed_rows.push_back('{-32'sd5,        4'd0,  4'd1,  1'b1, "5"});
    directed_rows.push_back('{32'd0,          4'd3,  4'd4,  1'b1, ".000"});
    directed_rows.push_back('{32'd7,          4'd0,  4'd15, 1'b0, ""});
    directed_rows.push_back('{32'd5,          4'd2,  4'd5,  1'b0, ""});
    directed_rows.push_back('{-32'sd5,        4'd2,  4'd6,  1'b0, ""});
    directed_rows.push_back('{32'd123456,     4'd3,  4'd10, 1'b0, ""});
    directed_rows.push_back('{32'd123456,     4'd3,  4'd4,  1'b0, ""});
    directed_rows.push_back('{-32'sd123456,   4'd3,  4'd8,  1'b0, ""});
    directed_rows.push_back('{32'd42,         4'd9,  4'd10, 1'b0, ""});
    directed_rows.push_back('{32'd42,         4'd10, 4'd10, 1'b0, ""});
    directed_rows.push_back('{-32'sd42,       4'd15, 4'd15, 1'b0, ""});
    directed_rows.push_back('{32'h8000_0000,  4'd9,  4'd10, 1'b0, ""});
    directed_rows.push_back('{32'hFFFF_FFFF,  4'd9,  4'd10, 1'b0, ""});
    directed_rows.push_back('{32'h7FFF_FFFF,  4'd5,  4'd8,  1'b0, ""});
    directed_rows.push_back('{32'd100,        4'd1,  4'd2,  1'b0, ""});
    directed_rows.push_back('{-32'sd100,      4'd2,  4'd3,  1'b0, ""});
    directed_rows.push_back('{-32'sd9,        4'd1,  4'd4,  1'b0, ""});
    directed_rows.push_back('{32'h5555_5555,  4'd6,  4'd12, 1'b0, ""});
    directed_rows.push_back('{32'hAAAA_AAAA,  4'd0,  4'd9,  1'b0, ""});
    directed_count = directed_rows.size();

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_rows[r]) begin
      drive_item(directed_rows[r].value, directed_rows[r].point, directed_rows[r].width,
                 directed_rows[r].typed, directed_rows[r].text);
    end

    // Random items over three stall patterns: sender light and receiver
    // heavy, then the reverse, then none at all.
    for (phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 38 : (phase == 1) ? 66 : 0;
      recv_idle_pct = (phase == 0) ? 66 : (phase == 1) ? 38 : 0;
      repeat (42) begin
        case ($urandom_range(9))
          0, 1, 2, 3: value = $urandom;
          4, 5, 6:    value = VALUE_W'($signed($urandom_range(1998)) - 999);
          7: begin
            case ($urandom_range(3))
              0:       value = 32'h8000_0000;
              1:       value = 32'h7FFF_FFFF;
              2:       value = 32'h0000_0000;
              default: value = 32'hFFFF_FFFF;
            endcase
          end
          default:    value = VALUE_W'($signed($urandom_range(2000000)) - 1000000);
        endcase
        point = ($urandom_range(9) < 8) ? POINT_W'($urandom_range(9))
                                        : POINT_W'($urandom_range(15, 10));
        // The out-of-range picks wrap 16 round to a width of zero.
        width = ($urandom_range(9) < 8) ? FIELD_W'($urandom_range(10, 1))
                                        : FIELD_W'($urandom_range(16, 11));
        drive_item(value, point, width, 1'b0, "");
      end
    end
    item_ch.valid <= 1'b0;

    while (expected_chars.size() != 0) @(posedge clk);
    tail = 0;
    while (tail < 40) begin
      @(posedge clk);
      tail++;
    end

    $display("Covered %0d items (%0d directed, the rest random over three stall patterns).",
             items_sent, directed_count);
    $display("Checked %0d characters across %0d fields; failures seen: %0d.",
             chars_checked, fields_checked, failures);
    if (failures == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/fpdtf_pkg.sv
sv/fpdtf_if.sv
sv/fpdtf_front.sv
sv/fpdtf_queue.sv
sv/fpdtf_back.sv
sv/fixed_point_decimal_text_formatter_core.sv
sv/fpdtf_checker.sv
bench/tb.sv
